// File: rtl/tao_pkg.sv
package tao_pkg;

  localparam int AngleBits = 16;
  localparam int FracBits = 14;
  localparam int CordicSteps = 24;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGainInv = 34'sd652032874;
  localparam int SqrtSteps = 31;
  localparam int VecW = 33;
  localparam int SumW = 62;
  localparam int QuoW = FracBits + 2;
  localparam int NumW = VecW + FracBits + 2;
  localparam int DivW = 33;
  localparam int FifoDepth = 4;

  typedef struct packed {
    logic signed [16:0] nx;
    logic signed [16:0] ny;
    logic signed [16:0] nz;
    logic [AngleBits-1:0] heading;
    logic signed [24:0] ph;
  } front_item_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [VecW-1:0] z;
  } vec_t;

  function automatic logic signed [CordicW-1:0] atan_tab(input int i);
    logic signed [CordicW-1:0] t;
    case (i)
      0: t = 34'sh20000000;  1: t = 34'sh12E4051E;  2: t = 34'sh09FB385B;
      3: t = 34'sh051111D4;  4: t = 34'sh028B0D43;  5: t = 34'sh0145D7E1;
      6: t = 34'sh00A2F61E;  7: t = 34'sh00517C55;  8: t = 34'sh0028BE53;
      9: t = 34'sh00145F2F;  10: t = 34'sh000A2F98; 11: t = 34'sh000517CC;
      12: t = 34'sh00028BE6; 13: t = 34'sh000145F3; 14: t = 34'sh0000A2FA;
      15: t = 34'sh0000517D; 16: t = 34'sh000028BE; 17: t = 34'sh0000145F;
      18: t = 34'sh00000A30; 19: t = 34'sh00000518; 20: t = 34'sh0000028C;
      21: t = 34'sh00000146; 22: t = 34'sh000000A3; default: t = 34'sh00000051;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/terrain_aligned_orientation.sv
// Terrain-aligned orientation: per item, turns a terrain normal, a binary-angle
// heading and a ground height into a Q1.14 rotation matrix (columns: heading axis
// crossed with the inverted normal, its partner, and the inverted normal, each
// normalized) plus the ground height less height_offset, saturated. A zero-length
// column reads as zeros and raises degenerate. Throughput is one transfer per
// cycle; the back pipeline holds a 24-stage CORDIC, a 31-stage bit-per-stage square
// root and a 16-stage restoring divider, plus prep, rounding, product, sum and
// output registers. An item passes through the intake FIFO and then the back
// pipeline, whose output register holds each result until it is taken.
// A four-entry intake FIFO separates the input handshake from the pipeline, which
// freezes as a whole only while a finished result waits at the output.
module terrain_aligned_orientation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]        heading_i,
  input  logic signed [23:0] ground_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m31_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m22_o,
  output logic signed [15:0] m32_o,
  output logic signed [15:0] m13_o,
  output logic signed [15:0] m23_o,
  output logic signed [15:0] m33_o,
  output logic signed [23:0] placed_height_o,
  output logic               degenerate_o
);
  import tao_pkg::*;

  logic [7:0] offset_q;
  front_item_t item;
  logic fv, fr;
  logic signed [15:0] m [9];

  // Hold the offset register; accept a write every cycle.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) offset_q <= 8'd6;
    else if (cfg_valid_i) offset_q <= cfg_data_i;
  end

  tao_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .normal_x_i, .normal_y_i, .normal_z_i, .heading_i, .ground_height_i,
    .height_offset_i(offset_q),
    .valid_o(fv), .ready_i(fr), .item_o(item)
  );

  tao_back u_back (
    .clk_i, .rst_ni,
    .valid_i(fv), .ready_o(fr), .item_i(item),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .m_o(m), .ph_o(placed_height_o), .deg_o(degenerate_o)
  );

  assign m11_o = m[0]; assign m21_o = m[1]; assign m31_o = m[2];
  assign m12_o = m[3]; assign m22_o = m[4]; assign m32_o = m[5];
  assign m13_o = m[6]; assign m23_o = m[7]; assign m33_o = m[8];

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o && !out_ready_i
    |=> out_valid_o && $stable(m11_o) && $stable(degenerate_o)) else $error("stall lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_valid_i && !in_ready_o
    |=> in_valid_i) else $error("input withdrawn");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_valid_i |=> offset_q == $past(cfg_data_i))
    else $error("offset write lost");
endmodule

// File: rtl/tao_front.sv
module tao_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [15:0]  normal_x_i,
  input  logic signed [15:0]  normal_y_i,
  input  logic signed [15:0]  normal_z_i,
  input  logic [15:0]         heading_i,
  input  logic signed [23:0]  ground_height_i,
  input  logic [7:0]          height_offset_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tao_pkg::front_item_t item_o
);
  import tao_pkg::*;

  // Small FIFO decouples intake from the arithmetic pipeline.
  localparam int AW = $clog2(FifoDepth);
  front_item_t mem_q [FifoDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic push, pop;
  front_item_t in_item;
  logic signed [24:0] ph;

  always_comb begin
    ph = 25'(ground_height_i) - 25'(signed'({1'b0, height_offset_i}));
    if (ph < -25'sd8388608) ph = -25'sd8388608;
    in_item.nx = -17'(normal_x_i);
    in_item.ny = -17'(normal_y_i);
    in_item.nz = -17'(normal_z_i);
    in_item.heading = heading_i[AngleBits-1:0];
    in_item.ph = ph;
  end

  assign ready_o = (cnt_q != (AW+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;
  assign item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AW+1)'(FifoDepth))
    else $error("fifo overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push && !pop |=> cnt_q != '0)
    else $error("push lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty");
endmodule

// File: rtl/tao_back.sv
module tao_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  tao_pkg::front_item_t item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [15:0]   m_o [9],
  output logic signed [23:0]   ph_o,
  output logic                 deg_o
);
  import tao_pkg::*;

  // Depth: 1 prep + CordicSteps + 1 round + 1 mul + 1 sum + SqrtSteps + divider + 1 out
  localparam int DivStages = QuoW;
  localparam int Lat = 1 + CordicSteps + 1 + 1 + 1 + SqrtSteps + DivStages;

  logic adv;
  logic [Lat-1:0] v_q;
  logic ovalid_q;
  logic signed [15:0] om_q [9];
  logic signed [23:0] oph_q;
  logic odeg_q;

  // Pipeline advances whenever the output slot is free or being drained.
  assign adv = !ovalid_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0; ovalid_q <= 1'b0;
    end else if (adv) begin
      v_q <= {v_q[Lat-2:0], valid_i};
      ovalid_q <= v_q[Lat-1];
    end
  end

  // ---------------- CORDIC ----------------
  logic signed [CordicW-1:0] cx_q [CordicSteps+1];
  logic signed [CordicW-1:0] cy_q [CordicSteps+1];
  logic signed [CordicW-1:0] cz_q [CordicSteps+1];
  logic [1:0] cq_q [CordicSteps+1];
  logic signed [16:0] nx_q [CordicSteps+4];
  logic signed [16:0] ny_q [CordicSteps+4];
  logic signed [16:0] nz_q [CordicSteps+4];
  logic signed [24:0] phl_q [Lat];

  logic [31:0] ang;
  logic [1:0] q0;
  logic [31:0] d0;
  assign ang = {item_i.heading, {(32-AngleBits){1'b0}}};
  assign q0 = 2'((ang + 32'h20000000) >> 30);
  assign d0 = ang - {q0, 30'd0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= CordicGainInv;
      cy_q[0] <= '0;
      cz_q[0] <= CordicW'(signed'(d0));
      cq_q[0] <= q0;
      nx_q[0] <= item_i.nx; ny_q[0] <= item_i.ny; nz_q[0] <= item_i.nz;
      phl_q[0] <= item_i.ph;
      for (int i = 1; i < Lat; i++) phl_q[i] <= phl_q[i-1];
      for (int i = 1; i < CordicSteps+4; i++) begin
        nx_q[i] <= nx_q[i-1]; ny_q[i] <= ny_q[i-1]; nz_q[i] <= nz_q[i-1];
      end
      for (int i = 0; i < CordicSteps; i++) begin
        cq_q[i+1] <= cq_q[i];
        if (!cz_q[i][CordicW-1]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - atan_tab(i);
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + atan_tab(i);
        end
      end
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] r;
    r = (v + CordicW'(32768)) >>> 16;
    if (r > CordicW'(16384)) r = CordicW'(16384);
    if (r < -CordicW'(16384)) r = -CordicW'(16384);
    return r[15:0];
  endfunction

  logic signed [15:0] xr, yr;
  logic signed [15:0] c_q, s_q;
  assign xr = to_q14(cx_q[CordicSteps]);
  assign yr = to_q14(cy_q[CordicSteps]);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      unique case (cq_q[CordicSteps])
        2'd0: begin c_q <= xr; s_q <= yr; end
        2'd1: begin c_q <= -yr; s_q <= xr; end
        2'd2: begin c_q <= -xr; s_q <= -yr; end
        default: begin c_q <= yr; s_q <= -xr; end
      endcase
    end
  end

  // ---------------- products ----------------
  localparam int K1 = CordicSteps + 1;
  logic signed [VecW-1:0] zc_q, zs_q, xc_q, ys_q, xs_q, yc_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zc_q <= VecW'(nz_q[K1] * c_q); zs_q <= VecW'(nz_q[K1] * s_q);
      xc_q <= VecW'(nx_q[K1] * c_q); ys_q <= VecW'(ny_q[K1] * s_q);
      xs_q <= VecW'(nx_q[K1] * s_q); yc_q <= VecW'(ny_q[K1] * c_q);
    end
  end

  vec_t vec0_q [3];
  logic [SumW-1:0] sum0_q [3];
  vec_t vnow [3];
  always_comb begin
    vnow[0].x = zc_q; vnow[0].y = zs_q; vnow[0].z = -xc_q - ys_q;
    vnow[1].x = -zs_q; vnow[1].y = zc_q; vnow[1].z = xs_q - yc_q;
    vnow[2].x = VecW'(nx_q[K1+1]); vnow[2].y = VecW'(ny_q[K1+1]);
    vnow[2].z = VecW'(nz_q[K1+1]);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        vec0_q[k] <= vnow[k];
        sum0_q[k] <= SumW'(vnow[k].x * vnow[k].x) + SumW'(vnow[k].y * vnow[k].y)
                   + SumW'(vnow[k].z * vnow[k].z);
      end
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [SumW-1:0] sv_q [3][SqrtSteps+1];
  logic [SumW-1:0] sr_q [3][SqrtSteps+1];
  vec_t sx_q [3][SqrtSteps+1];
  logic sz_q [3][SqrtSteps+1];
  for (genvar k = 0; k < 3; k++) begin : g_s0
    assign sv_q[k][0] = sum0_q[k];
    assign sr_q[k][0] = '0;
    assign sx_q[k][0] = vec0_q[k];
    assign sz_q[k][0] = (sum0_q[k] == '0);
  end
  for (genvar k = 0; k < 3; k++) begin : g_sq
    for (genvar j = 0; j < SqrtSteps; j++) begin : g_st
      localparam logic [SumW-1:0] B = SumW'(1) << (2*(SqrtSteps-1-j));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sx_q[k][j+1] <= sx_q[k][j];
          sz_q[k][j+1] <= sz_q[k][j];
          if (sv_q[k][j] >= sr_q[k][j] + B) begin
            sv_q[k][j+1] <= sv_q[k][j] - (sr_q[k][j] + B);
            sr_q[k][j+1] <= (sr_q[k][j] >> 1) + B;
          end else begin
            sv_q[k][j+1] <= sv_q[k][j];
            sr_q[k][j+1] <= sr_q[k][j] >> 1;
          end
        end
      end
    end
  end

  // ---------------- divider: q = (2m*2^F + r) / 2r, one bit per stage ----------------
  logic [NumW-1:0] dn_q [9][DivStages+1];
  logic [DivW:0]   dd_q [9][DivStages+1];
  logic [NumW-1:0] dp_q [9][DivStages+1];
  logic [QuoW-1:0] dqq_q [9][DivStages+1];
  logic dneg_q [9][DivStages+1];
  logic dz_q [3][DivStages+1];
  for (genvar k = 0; k < 3; k++) begin : g_d0
    logic signed [VecW-1:0] e [3];
    logic [DivW-1:0] r;
    assign e[0] = sx_q[k][SqrtSteps].x;
    assign e[1] = sx_q[k][SqrtSteps].y;
    assign e[2] = sx_q[k][SqrtSteps].z;
    assign r = DivW'(sr_q[k][SqrtSteps]);
    assign dz_q[k][0] = sz_q[k][SqrtSteps];
    for (genvar i = 0; i < 3; i++) begin : g_e
      logic [VecW-1:0] m;
      assign m = e[i][VecW-1] ? VecW'(-e[i]) : VecW'(e[i]);
      assign dneg_q[3*k+i][0] = e[i][VecW-1];
      assign dn_q[3*k+i][0] = (NumW'(m) << (FracBits+1)) + NumW'(r);
      assign dd_q[3*k+i][0] = {r, 1'b0};
      assign dp_q[3*k+i][0] = '0;
      assign dqq_q[3*k+i][0] = '0;
    end
  end
  // Quotient bits above QuoW-1 saturate; partial remainder restored per bit.
  for (genvar n = 0; n < 9; n++) begin : g_dv
    for (genvar j = 0; j < DivStages; j++) begin : g_ds
      localparam int Sh = DivStages - 1 - j;
      logic [NumW+QuoW:0] trial;
      logic ovf;
      assign trial = (NumW+QuoW+1)'(dd_q[n][j]) << Sh;
      assign ovf = (j == 0) && ((dn_q[n][j] >> (Sh+1)) >= NumW'(dd_q[n][j]));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dneg_q[n][j+1] <= dneg_q[n][j];
          dd_q[n][j+1] <= dd_q[n][j];
          dp_q[n][j+1] <= dp_q[n][j] | NumW'(ovf);
          if ((NumW+QuoW+1)'(dn_q[n][j]) >= trial) begin
            dn_q[n][j+1] <= dn_q[n][j] - NumW'(trial);
            dqq_q[n][j+1] <= dqq_q[n][j] | (QuoW'(1) << Sh);
          end else begin
            dn_q[n][j+1] <= dn_q[n][j];
            dqq_q[n][j+1] <= dqq_q[n][j];
          end
        end
      end
    end
  end
  for (genvar k = 0; k < 3; k++) begin : g_dz
    for (genvar j = 0; j < DivStages; j++) begin : g_dzs
      always_ff @(posedge clk_i) if (adv) dz_q[k][j+1] <= dz_q[k][j];
    end
  end

  // ---------------- output register ----------------
  localparam logic [QuoW-1:0] Lim = QuoW'(1) << FracBits;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      odeg_q <= dz_q[0][DivStages] | dz_q[1][DivStages] | dz_q[2][DivStages];
      oph_q <= phl_q[Lat-1][23:0];
      for (int n = 0; n < 9; n++) begin
        logic [QuoW:0] q;
        logic signed [15:0] mv;
        q = {1'b0, dqq_q[n][DivStages]};
        if (dp_q[n][DivStages] != '0 || q > {1'b0, Lim}) q = {1'b0, Lim};
        if (!dneg_q[n][DivStages] && q > (QuoW+1)'(32767)) q = (QuoW+1)'(32767);
        if (dz_q[n/3][DivStages]) mv = '0;
        else mv = dneg_q[n][DivStages] ? -16'(q) : 16'(q);
        om_q[n] <= mv;
      end
    end
  end

  assign valid_o = ovalid_q;
  assign m_o = om_q;
  assign ph_o = oph_q;
  assign deg_o = odeg_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q && !ready_i |=> ovalid_q)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q && !ready_i |=> $stable(oph_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !adv |=> $stable(v_q))
    else $error("pipeline moved while stalled");
endmodule

// File: tb/sv/terrain_aligned_orientation_tb.sv
module terrain_aligned_orientation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One output transfer, field by field.
  typedef struct packed {
    logic signed [15:0] m11;
    logic signed [15:0] m21;
    logic signed [15:0] m31;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
    logic signed [15:0] m32;
    logic signed [15:0] m13;
    logic signed [15:0] m23;
    logic signed [15:0] m33;
    logic signed [23:0] placed_height;
    logic               degenerate;
  } pose_t;

  // Holds its own copy of height_offset and the queue of predicted poses.
  class pose_scoreboard;
    logic [7:0] offset;
    pose_t      expected_poses[$];
    int         errors;

    function new();
      offset = 8'd6;
      errors = 0;
    endfunction

    // CORDIC angle table in 32-bit turn units.
    function longint atan_step(int i);
      longint t[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return t[i];
    endfunction

    function longint round_q14(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
    endfunction

    function void heading_trig(logic [15:0] hd, output longint c, output longint s);
      bit [31:0] a, q, d;
      int        zi;
      longint    x, y, z, xs, ys;
      a = {hd, 16'h0};
      q = ((a + 32'h2000_0000) >> 30) & 32'd3;
      d = a - q * 32'h4000_0000;
      zi = d;
      z = zi;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_step(i);
        end else begin
          x += ys; y -= xs; z += atan_step(i);
        end
      end
      x = round_q14(x);
      y = round_q14(y);
      case (q)
        0: begin c = x;  s = y;  end
        1: begin c = -y; s = x;  end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [15:0] unit_entry(longint v, longint unsigned r);
      longint unsigned m, q;
      longint          res;
      m = (v < 0) ? -v : v;
      q = ((m << 15) + r) / (2 * r);
      if (q > 16384) q = 16384;
      if (v >= 0 && q > 32767) q = 32767;
      if (q > 32768) q = 32768;
      res = (v < 0) ? -longint'(q) : longint'(q);
      return res[15:0];
    endfunction

    // Normalize one column; a zero vector gives zeros and flags degenerate.
    function bit unit_column(longint x, longint y, longint z,
                             output logic [15:0] e0, output logic [15:0] e1,
                             output logic [15:0] e2);
      longint unsigned len2, r;
      len2 = longint'(x * x) + longint'(y * y) + longint'(z * z);
      if (len2 == 0) begin
        e0 = '0; e1 = '0; e2 = '0;
        return 1'b1;
      end
      r = root_floor(len2);
      e0 = unit_entry(x, r);
      e1 = unit_entry(y, r);
      e2 = unit_entry(z, r);
      return 1'b0;
    endfunction

    function void note_input(logic signed [15:0] nx_i, logic signed [15:0] ny_i,
                             logic signed [15:0] nz_i, logic [15:0] hd,
                             logic signed [23:0] gh);
      longint nx, ny, nz, c, s, ph;
      bit     deg;
      pose_t  p;
      nx = -longint'(nx_i);
      ny = -longint'(ny_i);
      nz = -longint'(nz_i);
      heading_trig(hd, c, s);
      deg = unit_column(nz * c, nz * s, -nx * c - ny * s, p.m11, p.m21, p.m31);
      deg |= unit_column(-nz * s, nz * c, nx * s - ny * c, p.m12, p.m22, p.m32);
      deg |= unit_column(nx, ny, nz, p.m13, p.m23, p.m33);
      ph = longint'(gh) - longint'(offset);
      if (ph < -8388608) ph = -8388608;
      p.placed_height = ph[23:0];
      p.degenerate = deg;
      expected_poses.push_back(p);
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pose(pose_t a);
      pose_t e;
      if (expected_poses.size() == 0) begin
        $error("unexpected output transfer");
        errors++;
        return;
      end
      e = expected_poses.pop_front();
      compare("m11", e.m11, a.m11);
      compare("m21", e.m21, a.m21);
      compare("m31", e.m31, a.m31);
      compare("m12", e.m12, a.m12);
      compare("m22", e.m22, a.m22);
      compare("m32", e.m32, a.m32);
      compare("m13", e.m13, a.m13);
      compare("m23", e.m23, a.m23);
      compare("m33", e.m33, a.m33);
      compare("placed_height", e.placed_height, a.placed_height);
      compare("degenerate", e.degenerate, a.degenerate);
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               cfg_valid_i, cfg_ready_o;
  logic [7:0]         cfg_data_i;
  logic               in_valid_i, in_ready_o;
  logic signed [15:0] normal_x_i, normal_y_i, normal_z_i;
  logic [15:0]        heading_i;
  logic signed [23:0] ground_height_i;
  logic               out_valid_o, out_ready_i;
  pose_t              seen;

  terrain_aligned_orientation uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .normal_x_i, .normal_y_i, .normal_z_i,
    .heading_i, .ground_height_i, .out_valid_o, .out_ready_i,
    .m11_o(seen.m11), .m21_o(seen.m21), .m31_o(seen.m31),
    .m12_o(seen.m12), .m22_o(seen.m22), .m32_o(seen.m32),
    .m13_o(seen.m13), .m23_o(seen.m23), .m33_o(seen.m33),
    .placed_height_o(seen.placed_height), .degenerate_o(seen.degenerate)
  );

  pose_scoreboard sb = new();
  bit             burst;        // no sender gaps or receiver stalls while set
  bit             long_hold;    // request one long receiver stall
  longint         cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 2_000_000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver: random stall before each transfer, plus one long hold-off.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 14);
      if (long_hold) begin
        stall = 400;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_pose(seen);
    end
  end

  task automatic write_offset(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.offset = v;
  endtask

  // Offer one item after a random gap; valid stays up if the next gap is zero.
  task automatic send_item(logic signed [15:0] nx, logic signed [15:0] ny,
                           logic signed [15:0] nz, logic [15:0] hd,
                           logic signed [23:0] gh);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    normal_x_i      <= nx;
    normal_y_i      <= ny;
    normal_z_i      <= nz;
    heading_i       <= hd;
    ground_height_i <= gh;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(nx, ny, nz, hd, gh);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_poses.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic random_items(int n);
    logic signed [23:0] gh;
    for (int i = 0; i < n; i++) begin
      burst = (i % 150) >= 120;
      if (i == 40) long_hold = 1'b1;
      case ($urandom_range(0, 3))
        0: gh = 24'sh800000 + 24'($urandom_range(0, 300));
        1: gh = 24'sh7FFFFF - 24'($urandom_range(0, 300));
        default: gh = 24'($urandom);
      endcase
      send_item(pick_component(), pick_component(), pick_component(),
                16'($urandom), gh);
    end
    burst = 1'b0;
  endtask

  initial begin
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    normal_x_i = '0; normal_y_i = '0; normal_z_i = '0;
    heading_i = '0; ground_height_i = '0;
    burst = 1'b0; long_hold = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset offset, flat ground, quadrant headings, extremes.
    send_item(0, 0, -16384, 16'h0000, 24'sd1000);
    send_item(0, 0, -16384, 16'h4000, 24'sd0);
    send_item(0, 0, -16384, 16'h8000, 24'sd5);
    send_item(0, 0, -16384, 16'hC000, -24'sd1);
    send_item(0, 0, -16384, 16'h2000, 24'sh800000);
    send_item(0, 0, -16384, 16'h1FFF, 24'sh7FFFFF);
    send_item(0, 0, -16384, 16'hFFFF, 24'sd6);
    // zero normal: every column degenerate
    send_item(0, 0, 0, 16'h1234, 24'sd0);
    // level normal along y at heading zero: first column collapses
    send_item(0, 16'sd9000, 0, 16'h0000, 24'sd7);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'h6000, 24'sd0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hA000, 24'sd0);
    send_item(16'sh8000, 0, 0, 16'h5555, 24'sd0);
    send_item(1, 0, 0, 16'hAAAA, 24'sd0);
    send_item(0, 0, 1, 16'h0001, 24'sd0);
    drain();

    write_offset(8'd255);
    send_item(0, 0, -16384, 16'h0000, 24'sh800000);
    send_item(0, 0, -16384, 16'h0000, 24'sh8000FE);
    send_item(0, 0, -16384, 16'h0000, 24'sh7FFFFF);
    random_items(450);
    drain();

    write_offset(8'd0);
    send_item(0, 0, -16384, 16'h0000, 24'sh800000);
    random_items(450);
    drain();

    write_offset(8'($urandom));
    random_items(450);
    drain();

    write_offset(8'd6);
    random_items(430);
    drain();

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_poses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
